// ----- rtl/alu16_pkg.sv -----
package alu16_pkg;

  // Operand, flag, command and step-counter widths.
  localparam int DATA_W = 16;
  localparam int FLAG_W = 4;
  localparam int CMD_W  = 6;
  localparam int CNT_W  = $clog2(DATA_W + 1);

  // Flag bit positions inside the status word.
  localparam int FLG_Z = 0;
  localparam int FLG_C = 1;
  localparam int FLG_N = 2;
  localparam int FLG_V = 3;

  // Operation codes.
  typedef enum logic [CMD_W-1:0] {
    OP_ADD   = 6'd0,  OP_SUB   = 6'd1,  OP_MULT  = 6'd2,  OP_DIV   = 6'd3,
    OP_MOD   = 6'd4,  OP_AND   = 6'd5,  OP_OR    = 6'd6,  OP_XOR   = 6'd7,
    OP_NOT   = 6'd8,  OP_NAND  = 6'd9,  OP_NOR   = 6'd10, OP_NEG   = 6'd11,
    OP_LSH   = 6'd12, OP_RSH   = 6'd13, OP_ROL   = 6'd14, OP_ROR   = 6'd15,
    OP_EQ    = 6'd16, OP_NE    = 6'd17, OP_LT    = 6'd18, OP_LE    = 6'd19,
    OP_GT    = 6'd20, OP_GE    = 6'd21, OP_ULT   = 6'd22, OP_ULE   = 6'd23,
    OP_UGT   = 6'd24, OP_UGE   = 6'd25, OP_SETZ  = 6'd26, OP_CLRZ  = 6'd27,
    OP_SETC  = 6'd28, OP_CLRC  = 6'd29, OP_SETN  = 6'd30, OP_CLRN  = 6'd31,
    OP_COMP  = 6'd32, OP_MULTS = 6'd33, OP_DIVS  = 6'd34, OP_MODS  = 6'd35,
    OP_TZ    = 6'd36, OP_TNZ   = 6'd37, OP_TN    = 6'd38, OP_TNN   = 6'd39,
    OP_TPOS  = 6'd40, OP_TNPOS = 6'd41
  } op_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_CALC
  } st_t;

  // Status of the shared divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // True for the operations that go through the divider.
  function automatic logic is_div_op(input logic [CMD_W-1:0] cmd);
    return (cmd == OP_DIV) || (cmd == OP_MOD) || (cmd == OP_DIVS) || (cmd == OP_MODS);
  endfunction

  // True for the signed divide and modulo.
  function automatic logic is_sdiv_op(input logic [CMD_W-1:0] cmd);
    return (cmd == OP_DIVS) || (cmd == OP_MODS);
  endfunction

endpackage

// ----- rtl/alu16_with_flags_and_conditions_unit.sv -----
// 16-bit execute unit with zero, carry, negative and overflow flags.
// Input channel: in_valid/in_stall with in_cmd, in_operand_a and in_operand_b.
// A transfer takes place at a rising edge with in_valid high and in_stall low.
// Result channel: out_valid/out_stall with the result word, its write-enable,
// the condition bit, the flags after the operation and the bad-code bit.
// Exactly one result leaves for every accepted item, in order.
// Every operation passes from the operand registers through the CALC state into
// the output register; divide and modulo first wait in the DIV state for the
// shared restoring divider, which retires one quotient bit per cycle. in_stall
// is high from the input transfer until the result is loaded into the output
// register, so one item is in flight: a new item is taken only after the
// previous one has been loaded into the output register.
// The output register holds its result while out_stall is high; the next item
// may be accepted meanwhile and waits in the unit until the register frees.
// Reset clears the flags to zero, empties the output register and returns the
// sequencer to idle.
module alu16_with_flags_and_conditions_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [alu16_pkg::CMD_W-1:0]   in_cmd,
  input  logic [alu16_pkg::DATA_W-1:0]  in_operand_a,
  input  logic [alu16_pkg::DATA_W-1:0]  in_operand_b,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [alu16_pkg::DATA_W-1:0]  out_result,
  output logic                          out_result_valid,
  output logic                          out_condition_true,
  output logic [alu16_pkg::FLAG_W-1:0]  out_flags_out,
  output logic                          out_bad_code
);
  import alu16_pkg::*;

  st_t               state_r, state_nxt;
  logic [CMD_W-1:0]  cmd_r;
  logic [DATA_W-1:0] a_r;
  logic [DATA_W-1:0] b_r;
  logic [FLAG_W-1:0] flags_r, flags_nxt;

  logic              out_valid_r;
  logic [DATA_W-1:0] res_r, res_nxt;
  logic              wen_r, wen_nxt;
  logic              cond_r, cond_nxt;
  logic              bad_r, bad_nxt;

  logic              accept;
  logic              load;
  logic              slot_free;
  logic              div_start;
  logic [DATA_W-1:0] bd_in;
  logic [DATA_W-1:0] div_a, div_b;
  logic [DATA_W-1:0] div_q, div_rem;
  div_stat_t         div_stat;

  logic [DATA_W:0]     sum;
  logic [DATA_W:0]     diff;
  logic [2*DATA_W-1:0] prod;
  logic [2*DATA_W-1:0] rol_w;
  logic [2*DATA_W-1:0] ror_w;
  logic                big_shift;
  logic                sub_v;
  logic                add_v;
  logic                neg_q;
  logic                neg_r;

  // Handshake and sequencer control.
  always_comb begin
    state_nxt = state_r;
    slot_free = !out_valid_r || !out_stall;
    in_stall  = (state_r != ST_IDLE);
    accept    = in_valid && !in_stall;
    load      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = is_div_op(in_cmd) ? ST_DIV : ST_CALC;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        if (slot_free) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Operand capture on an input transfer.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_cmd;
      a_r   <= in_operand_a;
      b_r   <= in_operand_b;
    end
  end

  // Divider operands: zero divisor counts as one, signed ops use magnitudes.
  always_comb begin
    bd_in     = (in_operand_b == '0) ? DATA_W'(1) : in_operand_b;
    div_a     = in_operand_a;
    div_b     = bd_in;
    if (is_sdiv_op(in_cmd)) begin
      if (in_operand_a[DATA_W-1]) begin
        div_a = '0 - in_operand_a;
      end
      if (bd_in[DATA_W-1]) begin
        div_b = '0 - bd_in;
      end
    end
    div_start = accept && is_div_op(in_cmd);
  end

  alu16_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .quotient  (div_q),
    .remainder (div_rem),
    .stat      (div_stat)
  );

  // Shared arithmetic and sign terms used in the CALC state.
  always_comb begin
    sum       = {1'b0, a_r} + {1'b0, b_r};
    diff      = {1'b0, a_r} - {1'b0, b_r};
    prod      = a_r * b_r;
    rol_w     = {a_r, a_r} << b_r[3:0];
    ror_w     = {a_r, a_r} >> b_r[3:0];
    big_shift = (b_r[DATA_W-1:4] != '0);
    add_v     = (a_r[DATA_W-1] == b_r[DATA_W-1]) && (a_r[DATA_W-1] != sum[DATA_W-1]);
    sub_v     = (a_r[DATA_W-1] != b_r[DATA_W-1]) && (a_r[DATA_W-1] != diff[DATA_W-1]);
    // Signed quotient is negated when the operand signs differ; the divisor
    // sign is that of the raw operand, since zero becomes plus one.
    neg_q     = a_r[DATA_W-1] != b_r[DATA_W-1];
    neg_r     = a_r[DATA_W-1];
  end

  // Result, condition and flag update for the operation in progress.
  always_comb begin
    res_nxt   = '0;
    wen_nxt   = 1'b0;
    cond_nxt  = 1'b0;
    bad_nxt   = 1'b0;
    flags_nxt = flags_r;
    unique case (op_t'(cmd_r))
      OP_ADD: begin
        res_nxt = sum[DATA_W-1:0];
        wen_nxt = 1'b1;
        flags_nxt[FLG_C] = sum[DATA_W];
        flags_nxt[FLG_Z] = (sum[DATA_W-1:0] == '0);
        flags_nxt[FLG_N] = sum[DATA_W-1];
        flags_nxt[FLG_V] = add_v;
      end
      OP_SUB, OP_COMP: begin
        res_nxt = (op_t'(cmd_r) == OP_SUB) ? diff[DATA_W-1:0] : '0;
        wen_nxt = (op_t'(cmd_r) == OP_SUB);
        flags_nxt[FLG_C] = diff[DATA_W];
        flags_nxt[FLG_Z] = (diff[DATA_W-1:0] == '0);
        flags_nxt[FLG_N] = diff[DATA_W-1];
        flags_nxt[FLG_V] = sub_v;
      end
      OP_MULT, OP_MULTS: begin
        res_nxt = prod[DATA_W-1:0];
        wen_nxt = 1'b1;
      end
      OP_DIV: begin
        res_nxt = div_q;
        wen_nxt = 1'b1;
      end
      OP_MOD: begin
        res_nxt = div_rem;
        wen_nxt = 1'b1;
      end
      OP_DIVS: begin
        res_nxt = neg_q ? ('0 - div_q) : div_q;
        wen_nxt = 1'b1;
      end
      OP_MODS: begin
        res_nxt = neg_r ? ('0 - div_rem) : div_rem;
        wen_nxt = 1'b1;
      end
      OP_AND: begin
        res_nxt = a_r & b_r;
        wen_nxt = 1'b1;
      end
      OP_OR: begin
        res_nxt = a_r | b_r;
        wen_nxt = 1'b1;
      end
      OP_XOR: begin
        res_nxt = a_r ^ b_r;
        wen_nxt = 1'b1;
      end
      OP_NOT: begin
        res_nxt = ~a_r;
        wen_nxt = 1'b1;
      end
      OP_NAND: begin
        res_nxt = ~(a_r & b_r);
        wen_nxt = 1'b1;
      end
      OP_NOR: begin
        res_nxt = ~(a_r | b_r);
        wen_nxt = 1'b1;
      end
      OP_NEG: begin
        res_nxt = '0 - a_r;
        wen_nxt = 1'b1;
      end
      OP_LSH: begin
        res_nxt = big_shift ? '0 : (a_r << b_r[3:0]);
        wen_nxt = 1'b1;
      end
      OP_RSH: begin
        res_nxt = big_shift ? '0 : (a_r >> b_r[3:0]);
        wen_nxt = 1'b1;
      end
      OP_ROL: begin
        res_nxt = rol_w[2*DATA_W-1:DATA_W];
        wen_nxt = 1'b1;
      end
      OP_ROR: begin
        res_nxt = ror_w[DATA_W-1:0];
        wen_nxt = 1'b1;
      end
      OP_EQ:    cond_nxt = (a_r == b_r);
      OP_NE:    cond_nxt = (a_r != b_r);
      OP_LT:    cond_nxt = ($signed(a_r) < $signed(b_r));
      OP_LE:    cond_nxt = ($signed(a_r) <= $signed(b_r));
      OP_GT:    cond_nxt = ($signed(a_r) > $signed(b_r));
      OP_GE:    cond_nxt = ($signed(a_r) >= $signed(b_r));
      OP_ULT:   cond_nxt = (a_r < b_r);
      OP_ULE:   cond_nxt = (a_r <= b_r);
      OP_UGT:   cond_nxt = (a_r > b_r);
      OP_UGE:   cond_nxt = (a_r >= b_r);
      OP_SETZ:  flags_nxt[FLG_Z] = 1'b1;
      OP_CLRZ:  flags_nxt[FLG_Z] = 1'b0;
      OP_SETC:  flags_nxt[FLG_C] = 1'b1;
      OP_CLRC:  flags_nxt[FLG_C] = 1'b0;
      OP_SETN:  flags_nxt[FLG_N] = 1'b1;
      OP_CLRN:  flags_nxt[FLG_N] = 1'b0;
      OP_TZ:    cond_nxt = flags_r[FLG_Z];
      OP_TNZ:   cond_nxt = !flags_r[FLG_Z];
      OP_TN:    cond_nxt = flags_r[FLG_N];
      OP_TNN:   cond_nxt = !flags_r[FLG_N];
      OP_TPOS:  cond_nxt = !flags_r[FLG_N] && !flags_r[FLG_Z];
      OP_TNPOS: cond_nxt = flags_r[FLG_N] || flags_r[FLG_Z];
      default:  bad_nxt = 1'b1;
    endcase
  end

  // Status flags and output register valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        flags_r     <= flags_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      res_r  <= res_nxt;
      wen_r  <= wen_nxt;
      cond_r <= cond_nxt;
      bad_r  <= bad_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result         = res_r;
  assign out_result_valid   = wen_r;
  assign out_condition_true = cond_r;
  assign out_flags_out      = flags_r;
  assign out_bad_code       = bad_r;

  // An input transfer never lands while the divider is still working.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !div_stat.busy)
    else $error("input transfer while divider busy");

  // The divider completes only while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == ST_DIV))
    else $error("divider completion outside divide state");

  // Flags move only when a result is loaded into the output register.
  assert property (@(posedge clk) disable iff (!rst_n)
    !load |=> $stable(flags_r))
    else $error("flags changed without a result load");

  // An undefined code produces no write-back and no condition.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && bad_r) |-> (!wen_r && !cond_r && (res_r == '0)))
    else $error("bad code with nonzero result fields");

endmodule

// ----- rtl/alu16_div.sv -----
module alu16_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [alu16_pkg::DATA_W-1:0]  dividend,
  input  logic [alu16_pkg::DATA_W-1:0]  divisor,
  output logic [alu16_pkg::DATA_W-1:0]  quotient,
  output logic [alu16_pkg::DATA_W-1:0]  remainder,
  output alu16_pkg::div_stat_t          stat
);
  import alu16_pkg::*;

  logic [CNT_W-1:0]  cnt_r;
  logic              done_r;
  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] quo_r;
  logic [DATA_W-1:0] dsr_r;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   trial;
  logic              fits;
  logic              busy;

  // One restoring step: shift in the next dividend bit and try to subtract.
  always_comb begin
    busy    = (cnt_r != '0);
    shifted = {rem_r, quo_r[DATA_W-1]};
    trial   = shifted - {1'b0, dsr_r};
    fits    = !trial[DATA_W];
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNT_W'(DATA_W);
      end else if (busy) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy) begin
      rem_r <= fits ? trial[DATA_W-1:0] : shifted[DATA_W-1:0];
      quo_r <= {quo_r[DATA_W-2:0], fits};
    end
  end

  assign quotient   = quo_r;
  assign remainder  = rem_r;
  assign stat.busy  = busy;
  assign stat.done  = done_r;

endmodule
